// ----- design/ldp_pkg.sv -----
`default_nettype none

package ldp_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FRAC_W = 28;
  localparam int unsigned IDX_W  = 3;

  // pipeline depth, input register to output register
  localparam int unsigned N_STG = 10;

  localparam logic signed [63:0] Q_ONE    = 64'sd268435456;
  localparam logic signed [63:0] HALF_LSB = 64'sd134217728;
  localparam logic signed [63:0] S32_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN  = -64'sd2147483648;

  localparam logic [31:0]        FOCAL_RST         = 32'd65536000;  // 1000.0 in Q16.16
  localparam logic signed [31:0] RADIAL_K3_DEFAULT = 32'sd0;

  typedef enum logic [IDX_W-1:0] {
    REG_FOCAL_X   = 3'd0,
    REG_FOCAL_Y   = 3'd1,
    REG_CENTER_X  = 3'd2,
    REG_CENTER_Y  = 3'd3,
    REG_RADIAL_1  = 3'd4,
    REG_RADIAL_2  = 3'd5,
    REG_TANGENT_1 = 3'd6,
    REG_TANGENT_2 = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] val;
    logic        hit;
  } sat_res_t;

  // clamp to signed 32 bits, flag when clamped
  function automatic sat_res_t sat32(input logic signed [63:0] v);
    sat_res_t res;
    if (v > S32_MAX) begin
      res.val = S32_MAX[31:0];
      res.hit = 1'b1;
    end else if (v < S32_MIN) begin
      res.val = S32_MIN[31:0];
      res.hit = 1'b1;
    end else begin
      res.val = v[31:0];
      res.hit = 1'b0;
    end
    return res;
  endfunction

  // Q4.28 product, round half up, saturate
  function automatic sat_res_t qmul(input logic signed [31:0] a,
                                    input logic signed [31:0] b);
    logic signed [63:0] prod;
    logic signed [63:0] rnd;
    prod = 64'(a) * 64'(b);
    rnd  = (prod + HALF_LSB) >>> FRAC_W;
    return sat32(rnd);
  endfunction

endpackage

`default_nettype wire

// ----- design/ldp_if.sv -----
`default_nettype none

interface ldp_in_if import ldp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] norm_x;
  logic signed [DATA_W-1:0] norm_y;

  modport source (output valid, output norm_x, output norm_y, input ready);
  modport sink   (input valid, input norm_x, input norm_y, output ready);
endinterface

interface ldp_out_if import ldp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pixel_u;
  logic signed [DATA_W-1:0] pixel_v;
  logic                     overflow;

  modport source (output valid, output pixel_u, output pixel_v, output overflow,
                  input ready);
  modport sink   (input valid, input pixel_u, input pixel_v, input overflow,
                  output ready);
endinterface

interface ldp_cfg_if import ldp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/lens_distortion_point_projector.sv -----
// Channel  | Dir | Payload                                  | Request taken when
// ---------+-----+------------------------------------------+--------------------
// in_ch    | in  | norm_x, norm_y (signed Q4.28)            | valid && ready
// out_ch   | out | pixel_u, pixel_v (signed Q16.16), overflow| valid && ready
// cfg_ch   | in  | index (register number), data            | valid (ready tied high)
//
// One request per cycle sustained while out_ch is not stalled; a request passes
// through the 10-stage pipeline from input accept to output valid.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults: focal lengths 1000.0, everything else zero.
// A stalled output freezes the whole pipeline; in_ch.ready drops in the same cycle.
`default_nettype none

module lens_distortion_point_projector import ldp_pkg::*; #(
  parameter logic signed [DATA_W-1:0] RADIAL_K3 = RADIAL_K3_DEFAULT
) (
  input  wire         clk,
  input  wire         rst_n,
  ldp_in_if.sink      in_ch,
  ldp_out_if.source   out_ch,
  ldp_cfg_if.sink     cfg_ch
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        [DATA_W-1:0] focal_x_r, focal_y_r;
  logic signed [DATA_W-1:0] center_x_r, center_y_r;
  logic signed [DATA_W-1:0] k1_r, k2_r, p1_r, p2_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= FOCAL_RST;
      focal_y_r  <= FOCAL_RST;
      center_x_r <= '0;
      center_y_r <= '0;
      k1_r       <= '0;
      k2_r       <= '0;
      p1_r       <= '0;
      p2_r       <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_FOCAL_X:   focal_x_r  <= cfg_ch.data;
        REG_FOCAL_Y:   focal_y_r  <= cfg_ch.data;
        REG_CENTER_X:  center_x_r <= cfg_ch.data;
        REG_CENTER_Y:  center_y_r <= cfg_ch.data;
        REG_RADIAL_1:  k1_r       <= cfg_ch.data;
        REG_RADIAL_2:  k2_r       <= cfg_ch.data;
        REG_TANGENT_1: p1_r       <= cfg_ch.data;
        REG_TANGENT_2: p2_r       <= cfg_ch.data;
        default:       ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: all stages advance together unless the output is stuck
  // ---------------------------------------------------------------------------
  logic             en;
  logic [N_STG-1:0] vld_r;
  logic [N_STG-1:0] ov_r;     // sticky saturation flag per stage
  logic [N_STG-1:0] ov_nxt;

  assign en          = !vld_r[N_STG-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N_STG-2:0], in_ch.valid};
    end
  end

  // input point travels alongside until the gain is applied (stage 7)
  logic signed [DATA_W-1:0] x_r [6];
  logic signed [DATA_W-1:0] y_r [6];

  // ---------------------------------------------------------------------------
  // Stage datapath
  // ---------------------------------------------------------------------------
  // s1: x*x, y*y, x*y
  sat_res_t q_xx, q_yy, q_xy;
  logic signed [31:0] s1_xx_r, s1_yy_r, s1_xy_r;
  // s2: r2
  sat_res_t q_r2;
  logic signed [31:0] s2_xx_r, s2_yy_r, s2_xy_r, s2_r2_r;
  // s3: r4, tangential sums, k1*r2, p*xy
  sat_res_t q_r4, q_tx, q_ty, q_k1r2, q_p1xy, q_p2xy;
  logic signed [31:0] s3_r2_r, s3_r4_r, s3_tx_r, s3_ty_r, s3_k1r2_r, s3_p1xy_r, s3_p2xy_r;
  // s4: r6, k2*r4, p2*tx, p1*ty
  sat_res_t q_r6, q_k2r4, q_p2tx, q_p1ty;
  logic signed [31:0] s4_r6_r, s4_k2r4_r, s4_k1r2_r, s4_p2tx_r, s4_p1ty_r;
  logic signed [31:0] s4_p1xy_r, s4_p2xy_r;
  // s5: k3*r6, partial gain (exact)
  sat_res_t q_k3r6;
  logic signed [34:0] s5_gpart_r;
  logic signed [31:0] s5_k3r6_r, s5_p2tx_r, s5_p1ty_r, s5_p1xy_r, s5_p2xy_r;
  // s6: gain
  sat_res_t q_gain;
  logic signed [31:0] s6_gain_r, s6_p2tx_r, s6_p1ty_r, s6_p1xy_r, s6_p2xy_r;
  // s7: x*g, y*g
  sat_res_t q_xg, q_yg;
  logic signed [31:0] s7_xg_r, s7_yg_r, s7_p2tx_r, s7_p1ty_r, s7_p1xy_r, s7_p2xy_r;
  // s8: distorted point
  sat_res_t q_xd, q_yd;
  logic signed [31:0] s8_xd_r, s8_yd_r;
  // s9: raw focal products
  logic signed [63:0] pu_nxt, pv_nxt;
  logic signed [63:0] s9_pu_r, s9_pv_r;
  // s10: pixel coordinates
  sat_res_t q_u, q_v;
  logic signed [31:0] s10_u_r, s10_v_r;

  always_comb begin
    q_xx   = qmul(in_ch.norm_x, in_ch.norm_x);
    q_yy   = qmul(in_ch.norm_y, in_ch.norm_y);
    q_xy   = qmul(in_ch.norm_x, in_ch.norm_y);

    q_r2   = sat32(64'(s1_xx_r) + 64'(s1_yy_r));

    q_r4   = qmul(s2_r2_r, s2_r2_r);
    q_tx   = sat32(64'(s2_r2_r) + (64'(s2_xx_r) <<< 1));
    q_ty   = sat32(64'(s2_r2_r) + (64'(s2_yy_r) <<< 1));
    q_k1r2 = qmul(k1_r, s2_r2_r);
    q_p1xy = qmul(p1_r, s2_xy_r);
    q_p2xy = qmul(p2_r, s2_xy_r);

    q_r6   = qmul(s3_r4_r, s3_r2_r);
    q_k2r4 = qmul(k2_r, s3_r4_r);
    q_p2tx = qmul(p2_r, s3_tx_r);
    q_p1ty = qmul(p1_r, s3_ty_r);

    q_k3r6 = qmul(RADIAL_K3, s4_r6_r);

    q_gain = sat32(64'(s5_gpart_r) + 64'(s5_k3r6_r));

    q_xg   = qmul(x_r[5], s6_gain_r);
    q_yg   = qmul(y_r[5], s6_gain_r);

    // the factor two goes on after p*xy is rounded
    q_xd   = sat32(64'(s7_xg_r) + (64'(s7_p1xy_r) <<< 1) + 64'(s7_p2tx_r));
    q_yd   = sat32(64'(s7_yg_r) + (64'(s7_p2xy_r) <<< 1) + 64'(s7_p1ty_r));

    // unsigned focal times signed coordinate fits a signed 64-bit product
    pu_nxt = $signed({32'd0, focal_x_r}) * 64'(s8_xd_r);
    pv_nxt = $signed({32'd0, focal_y_r}) * 64'(s8_yd_r);

    q_u    = sat32(((s9_pu_r + HALF_LSB) >>> FRAC_W) + 64'(center_x_r));
    q_v    = sat32(((s9_pv_r + HALF_LSB) >>> FRAC_W) + 64'(center_y_r));

    ov_nxt[0] = q_xx.hit | q_yy.hit | q_xy.hit;
    ov_nxt[1] = ov_r[0] | q_r2.hit;
    ov_nxt[2] = ov_r[1] | q_r4.hit | q_tx.hit | q_ty.hit | q_k1r2.hit
              | q_p1xy.hit | q_p2xy.hit;
    ov_nxt[3] = ov_r[2] | q_r6.hit | q_k2r4.hit | q_p2tx.hit | q_p1ty.hit;
    ov_nxt[4] = ov_r[3] | q_k3r6.hit;
    ov_nxt[5] = ov_r[4] | q_gain.hit;
    ov_nxt[6] = ov_r[5] | q_xg.hit | q_yg.hit;
    ov_nxt[7] = ov_r[6] | q_xd.hit | q_yd.hit;
    ov_nxt[8] = ov_r[7];
    ov_nxt[9] = ov_r[8] | q_u.hit | q_v.hit;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ov_r <= ov_nxt;

      x_r[0] <= in_ch.norm_x;
      y_r[0] <= in_ch.norm_y;
      for (int i = 1; i < 6; i++) begin
        x_r[i] <= x_r[i-1];
        y_r[i] <= y_r[i-1];
      end

      s1_xx_r <= q_xx.val;
      s1_yy_r <= q_yy.val;
      s1_xy_r <= q_xy.val;

      s2_xx_r <= s1_xx_r;
      s2_yy_r <= s1_yy_r;
      s2_xy_r <= s1_xy_r;
      s2_r2_r <= q_r2.val;

      s3_r2_r   <= s2_r2_r;
      s3_r4_r   <= q_r4.val;
      s3_tx_r   <= q_tx.val;
      s3_ty_r   <= q_ty.val;
      s3_k1r2_r <= q_k1r2.val;
      s3_p1xy_r <= q_p1xy.val;
      s3_p2xy_r <= q_p2xy.val;

      s4_r6_r   <= q_r6.val;
      s4_k2r4_r <= q_k2r4.val;
      s4_k1r2_r <= s3_k1r2_r;
      s4_p2tx_r <= q_p2tx.val;
      s4_p1ty_r <= q_p1ty.val;
      s4_p1xy_r <= s3_p1xy_r;
      s4_p2xy_r <= s3_p2xy_r;

      s5_k3r6_r  <= q_k3r6.val;
      s5_gpart_r <= 35'(Q_ONE + 64'(s4_k1r2_r) + 64'(s4_k2r4_r));
      s5_p2tx_r  <= s4_p2tx_r;
      s5_p1ty_r  <= s4_p1ty_r;
      s5_p1xy_r  <= s4_p1xy_r;
      s5_p2xy_r  <= s4_p2xy_r;

      s6_gain_r <= q_gain.val;
      s6_p2tx_r <= s5_p2tx_r;
      s6_p1ty_r <= s5_p1ty_r;
      s6_p1xy_r <= s5_p1xy_r;
      s6_p2xy_r <= s5_p2xy_r;

      s7_xg_r   <= q_xg.val;
      s7_yg_r   <= q_yg.val;
      s7_p2tx_r <= s6_p2tx_r;
      s7_p1ty_r <= s6_p1ty_r;
      s7_p1xy_r <= s6_p1xy_r;
      s7_p2xy_r <= s6_p2xy_r;

      s8_xd_r <= q_xd.val;
      s8_yd_r <= q_yd.val;

      s9_pu_r <= pu_nxt;
      s9_pv_r <= pv_nxt;

      s10_u_r <= q_u.val;
      s10_v_r <= q_v.val;
    end
  end

  assign out_ch.valid    = vld_r[N_STG-1];
  assign out_ch.pixel_u  = s10_u_r;
  assign out_ch.pixel_v  = s10_v_r;
  assign out_ch.overflow = ov_r[N_STG-1];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while output stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted request missing from first stage");

  a_stall_keeps_items: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> (vld_r == $past(vld_r)))
    else $error("pipeline valid bits moved during stall");

endmodule

`default_nettype wire
